/* rtl/signed_number_format_converter_defines.svh */
// Assertion macros for the checker file, snfc_checker.sv.
// Each sampled on clk, off while arst_n is low.
`ifndef SIGNED_NUMBER_FORMAT_CONVERTER_DEFINES_SVH
`define SIGNED_NUMBER_FORMAT_CONVERTER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SNFC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define SNFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/snfc_pkg.sv */
package snfc_pkg;

	typedef enum logic [1:0] {
		FMT_ONES = 2'd0,
		FMT_TWOS = 2'd1,
		FMT_SM   = 2'd2,
		FMT_DEC  = 2'd3
	} fmt_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDEF = 2'd1,
		ST_ERROR = 2'd2
	} status_t;

	// how stage 2 finishes a word
	typedef enum logic [1:0] {
		K_DIRECT,
		K_ENCODE,
		K_DECODE
	} kind_t;

	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
	localparam logic [31:0] MAG_MASK = 32'h7FFF_FFFF;
	localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
	localparam logic [31:0] DEC_MAX  = 32'd999999;

	// x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for x <= 999999
	localparam logic [20:0] DIV100_MUL   = 21'd1342178;
	localparam int          DIV100_SHIFT = 27;

	// stage enables, one per register stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} snfc_en_t;

	// word handed from the front end to the decimal encoder
	typedef struct packed {
		logic [31:0] word;
		status_t     status;
		logic        bcd;
		logic        sgn;
		logic [19:0] mag;
		logic [13:0] q1;
	} snfc_mid_t;

endpackage

/* rtl/snfc_front.sv */
// Stage 1: format decode and magnitude; stage 2: range check, decimal
// decode finish and first divide by 100.
module snfc_front import snfc_pkg::*; (
	input  logic        clk,
	input  snfc_en_t    en,
	input  logic [3:0]  opcode,
	input  logic [31:0] word_in,
	output snfc_mid_t   mid_s2
);

	fmt_t        src, dst;
	logic        neg;
	logic [4:0]  g0, g1, g2, g3, g4, g5;
	logic [21:0] dsum;

	kind_t       kind_a;
	logic [31:0] word_a;
	status_t     st_a;
	logic        sgn_a;
	logic [31:0] mag_a;

	kind_t       kind_s1;
	logic [31:0] word_s1;
	status_t     st_s1;
	logic        sgn_s1;
	logic [31:0] mag_s1;
	fmt_t        dst_s1;

	logic        over, zero, dneg;
	logic [40:0] prod;
	snfc_mid_t   mid_b;

	assign src = fmt_t'(opcode[3:2]);
	assign dst = fmt_t'(opcode[1:0]);
	assign neg = word_in[31];

	assign g0 = word_in[4:0];
	assign g1 = word_in[9:5];
	assign g2 = word_in[14:10];
	assign g3 = word_in[19:15];
	assign g4 = word_in[24:20];
	assign g5 = word_in[29:25];

	// each group at its full 5-bit value times its weight
	assign dsum = 22'(g0) + 22'(g1) * 22'd10 + 22'(g2) * 22'd100
		+ 22'(g3) * 22'd1000 + 22'(g4) * 22'd10000 + 22'(g5) * 22'd100000;

	always_comb begin
		kind_a = K_DIRECT;
		word_a = word_in;
		st_a   = ST_OK;
		sgn_a  = 1'b0;
		mag_a  = word_in;
		unique case (src)
			FMT_ONES: begin
				if (word_in == ALL_ONES) begin
					word_a = '0;
				end else if (dst == FMT_ONES || !neg) begin
					if (dst == FMT_DEC) kind_a = K_ENCODE;
				end else if (dst == FMT_TWOS) begin
					word_a = word_in + 32'd1;
				end else if (dst == FMT_SM) begin
					word_a = ~word_in | SIGN_BIT;
				end else begin
					kind_a = K_ENCODE;
					sgn_a  = 1'b1;
					mag_a  = ~word_in & MAG_MASK;
				end
			end
			FMT_TWOS: begin
				if (dst == FMT_TWOS) begin
					word_a = word_in;
				end else if (!neg) begin
					if (dst == FMT_DEC) kind_a = K_ENCODE;
				end else if (dst == FMT_ONES) begin
					if (word_in == SIGN_BIT) begin
						st_a   = ST_UNDEF;
						word_a = '0;
					end else begin
						word_a = word_in - 32'd1;
					end
				end else if (dst == FMT_SM) begin
					word_a = ~(word_in - 32'd1) | SIGN_BIT;
				end else begin
					kind_a = K_ENCODE;
					sgn_a  = 1'b1;
					mag_a  = (~word_in & MAG_MASK) + 32'd1;
				end
			end
			FMT_SM: begin
				if (word_in == SIGN_BIT) begin
					word_a = '0;
				end else if (dst == FMT_SM || !neg) begin
					if (dst == FMT_DEC) kind_a = K_ENCODE;
				end else if (dst == FMT_ONES) begin
					word_a = ~word_in | SIGN_BIT;
				end else if (dst == FMT_TWOS) begin
					word_a = (~word_in | SIGN_BIT) + 32'd1;
				end else begin
					kind_a = K_ENCODE;
					sgn_a  = 1'b1;
					mag_a  = word_in & MAG_MASK;
				end
			end
			FMT_DEC: begin
				if (dst == FMT_DEC) begin
					word_a = word_in;
				end else if (word_in[31] != word_in[30]) begin
					st_a   = ST_ERROR;
					word_a = '0;
				end else begin
					kind_a = K_DECODE;
					sgn_a  = word_in[31];
					mag_a  = 32'(dsum);
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			kind_s1 <= kind_a;
			word_s1 <= word_a;
			st_s1   <= st_a;
			sgn_s1  <= sgn_a;
			mag_s1  <= mag_a;
			dst_s1  <= dst;
		end
	end

	assign over = mag_s1 > DEC_MAX;
	assign zero = mag_s1 == '0;
	assign dneg = sgn_s1 && !zero;
	assign prod = 41'(mag_s1[19:0]) * 41'(DIV100_MUL);

	always_comb begin
		mid_b.word   = word_s1;
		mid_b.status = st_s1;
		mid_b.bcd    = 1'b0;
		mid_b.sgn    = dneg;
		mid_b.mag    = mag_s1[19:0];
		mid_b.q1     = 14'(prod >> DIV100_SHIFT);
		unique case (kind_s1)
			K_DIRECT: begin
			end
			K_ENCODE: begin
				mid_b.word = '0;
				if (over) mid_b.status = ST_UNDEF;
				else mid_b.bcd = 1'b1;
			end
			K_DECODE: begin
				if (over) begin
					mid_b.status = ST_UNDEF;
					mid_b.word   = '0;
				end else if (!dneg) begin
					mid_b.word = mag_s1;
				end else begin
					unique case (dst_s1)
						FMT_ONES: mid_b.word = ~mag_s1;
						FMT_TWOS: mid_b.word = 32'd0 - mag_s1;
						FMT_SM:   mid_b.word = mag_s1 | SIGN_BIT;
						FMT_DEC:  mid_b.word = mag_s1;
					endcase
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s2) mid_s2 <= mid_b;
	end

endmodule

/* rtl/snfc_bcd.sv */
// Stages 3 and 4: binary magnitude to six decimal digits, two digits
// per divide by 100, and the output register.
module snfc_bcd import snfc_pkg::*; (
	input  logic        clk,
	input  snfc_en_t    en,
	input  snfc_mid_t   mid_s2,
	output logic [31:0] word_s4,
	output status_t     status_s4
);

	// value below 100 to {tens, ones}
	function automatic logic [7:0] digits2(input logic [6:0] v);
		logic [14:0] p;
		logic [3:0]  t;
		logic [6:0]  o;
		p = 15'(v) * 15'd205;
		t = p[14:11];
		o = v - {t, 3'b000} - {2'b00, t, 1'b0};
		return {t, o[3:0]};
	endfunction

	logic [6:0]  r1;
	logic [34:0] prod2;

	logic [31:0] word_s3;
	status_t     st_s3;
	logic        bcd_s3;
	logic        sgn_s3;
	logic [7:0]  lo_s3;
	logic [13:0] q1_s3;
	logic [6:0]  q2_s3;

	logic [6:0]  r2;
	logic [7:0]  md, hi;
	logic [31:0] word_d;

	assign r1    = 7'(mid_s2.mag - 20'(mid_s2.q1) * 20'd100);
	assign prod2 = 35'(mid_s2.q1) * 35'(DIV100_MUL);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			word_s3 <= mid_s2.word;
			st_s3   <= mid_s2.status;
			bcd_s3  <= mid_s2.bcd;
			sgn_s3  <= mid_s2.sgn;
			lo_s3   <= digits2(r1);
			q1_s3   <= mid_s2.q1;
			q2_s3   <= 7'(prod2 >> DIV100_SHIFT);
		end
	end

	assign r2 = 7'(q1_s3 - 14'(q2_s3) * 14'd100);
	assign md = digits2(r2);
	assign hi = digits2(q2_s3);

	always_comb begin
		if (bcd_s3) begin
			word_d = {sgn_s3, sgn_s3,
				1'b0, hi[7:4], 1'b0, hi[3:0],
				1'b0, md[7:4], 1'b0, md[3:0],
				1'b0, lo_s3[7:4], 1'b0, lo_s3[3:0]};
		end else begin
			word_d = word_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			word_s4   <= word_d;
			status_s4 <= st_s3;
		end
	end

endmodule

/* rtl/signed_number_format_converter.sv */
// Channel   Direction  Handshake            Payload
// request   input      req_valid/req_stall  opcode[3:0], word_in[31:0]
// response  output     rsp_valid/rsp_stall  word_out[31:0], status[1:0]
//
// One word per cycle sustained unless rsp_stall; rsp_valid is the stage 4 valid bit.
// The depth is set by the four register stages; stages 2 and 3 each hold
// one divide-by-100 reciprocal multiply of the decimal encoder.
// arst_n clears the stage valid bits only; payload registers are not reset.
// rsp_stall holds the output word; bubbles fill first, then req_stall rises.
module signed_number_format_converter import snfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [3:0]  opcode,
	input  logic [31:0] word_in,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [31:0] word_out,
	output logic [1:0]  status
);

	// valid bits that travel with each stage
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// a stage may load when it is empty or its word moves on this cycle
	logic take1, take2, take3, take4;

	snfc_en_t  en;
	snfc_mid_t mid_s2;
	logic [31:0] word_s4;
	status_t     status_s4;

	assign take4 = !vld_s4 || !rsp_stall;
	assign take3 = !vld_s3 || take4;
	assign take2 = !vld_s2 || take3;
	assign take1 = !vld_s1 || take2;

	assign req_stall = !take1;
	assign rsp_valid = vld_s4;

	// payload registers only load when a real word arrives
	assign en.s1 = take1 && req_valid;
	assign en.s2 = take2 && vld_s1;
	assign en.s3 = take3 && vld_s2;
	assign en.s4 = take4 && vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (take1) vld_s1 <= req_valid;
			if (take2) vld_s2 <= vld_s1;
			if (take3) vld_s3 <= vld_s2;
			if (take4) vld_s4 <= vld_s3;
		end
	end

	// decode, magnitude, range check, first digit pair divide
	snfc_front u_front (
		.clk     (clk),
		.en      (en),
		.opcode  (opcode),
		.word_in (word_in),
		.mid_s2  (mid_s2)
	);

	// remaining digits and the output register
	snfc_bcd u_bcd (
		.clk       (clk),
		.en        (en),
		.mid_s2    (mid_s2),
		.word_s4   (word_s4),
		.status_s4 (status_s4)
	);

	assign word_out = word_s4;
	assign status   = status_s4;

endmodule

/* rtl/snfc_checker.sv */
`include "signed_number_format_converter_defines.svh"

module snfc_checker import snfc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic [3:0]  opcode,
	input logic [31:0] word_in,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [31:0] word_out,
	input logic [1:0]  status
);

	logic unused_ok;

	assign unused_ok = ^{req_valid, opcode, word_in};

	`SNFC_ASSERT_SAME(a_status_code, rsp_valid, (status == ST_OK || status == ST_UNDEF || status == ST_ERROR), "status code out of range")

	`SNFC_ASSERT_SAME(a_fail_zero, rsp_valid && status != ST_OK, word_out == 32'd0, "failed word not zero")

	`SNFC_ASSERT_SAME(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled with no blocked response")

	`SNFC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(word_out) && $stable(status), "stalled response changed")

endmodule

bind signed_number_format_converter snfc_checker u_snfc_checker (.*);

/* verif/tb_signed_number_format_converter.sv */
`timescale 1ns / 100ps

// Self-checking bench for the signed number format converter.
// A directed table hits every opcode and the corner words, then random words
// (mostly well-formed values in the source format) run with random gaps
// on the request side and random stalls on the response side.
module tb_signed_number_format_converter;
	import snfc_pkg::*;

	localparam int          CYCLE_LIMIT = 400_000;
	localparam int          RANDOM_WORDS = 850;
	localparam int          DRAIN_CYCLES = 10;   // pipeline is four deep
	localparam logic [31:0] DEC_NEG = 32'hC000_0000;   // decimal sign bits, negative

	// one expected response word
	typedef struct packed {
		logic [31:0] word;
		status_t     st;
	} result_t;

	// directed row; typed == 1 means the expectation is written out here
	typedef struct packed {
		fmt_t        src;
		fmt_t        dst;
		logic [31:0] word;
		logic        typed;
		logic [31:0] exp_word;
		status_t     exp_st;
	} probe_t;

	localparam probe_t PROBES [0:24] = '{
		// negative zero collapses to 0
		'{FMT_ONES, FMT_ONES, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_OK},
		'{FMT_SM,   FMT_SM,   32'h8000_0000, 1'b1, 32'h0000_0000, ST_OK},
		// two's minimum: no ones' form, fine in sign-magnitude, too big for decimal
		'{FMT_TWOS, FMT_ONES, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_UNDEF},
		'{FMT_TWOS, FMT_SM,   32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK},
		'{FMT_TWOS, FMT_DEC,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_UNDEF},
		'{FMT_TWOS, FMT_TWOS, 32'h8000_0000, 1'b1, 32'h8000_0000, ST_OK},
		// mixed decimal sign bits
		'{FMT_DEC,  FMT_TWOS, 32'h4000_0000, 1'b1, 32'h0000_0000, ST_ERROR},
		'{FMT_DEC,  FMT_ONES, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_ERROR},
		// decimal to decimal skips the sign check
		'{FMT_DEC,  FMT_DEC,  32'h4000_0001, 1'b1, 32'h4000_0001, ST_OK},
		// one million has no six-digit form
		'{FMT_ONES, FMT_DEC,  32'h000F_4240, 1'b1, 32'h0000_0000, ST_UNDEF},
		'{FMT_ONES, FMT_TWOS, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF, ST_OK},
		'{FMT_ONES, FMT_SM,   32'h8000_0000, 1'b0, 32'h0, ST_OK},
		'{FMT_ONES, FMT_DEC,  32'hFFF0_BDC0, 1'b0, 32'h0, ST_OK},   // -999999
		'{FMT_TWOS, FMT_ONES, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
		'{FMT_TWOS, FMT_DEC,  32'h000F_423F, 1'b0, 32'h0, ST_OK},   // +999999
		'{FMT_SM,   FMT_ONES, 32'h8000_0005, 1'b0, 32'h0, ST_OK},
		'{FMT_SM,   FMT_TWOS, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK},
		'{FMT_SM,   FMT_DEC,  32'h800F_423F, 1'b0, 32'h0, ST_OK},
		// negative decimal -654321 to sign-magnitude
		'{FMT_DEC,  FMT_SM,   32'hCC52_0C41, 1'b0, 32'h0, ST_OK},
		// decimal negative zero
		'{FMT_DEC,  FMT_TWOS, 32'hC000_0000, 1'b1, 32'h0000_0000, ST_OK},
		// every group at 31: sum is far past the decimal range
		'{FMT_DEC,  FMT_ONES, 32'h3FFF_FFFF, 1'b1, 32'h0000_0000, ST_UNDEF},
		// group above nine taken at face value
		'{FMT_DEC,  FMT_TWOS, 32'h0000_000F, 1'b0, 32'h0, ST_OK},
		'{FMT_ONES, FMT_ONES, 32'h7FFF_FFFF, 1'b0, 32'h0, ST_OK},
		'{FMT_SM,   FMT_SM,   32'h0000_0000, 1'b0, 32'h0, ST_OK},
		'{FMT_DEC,  FMT_SM,   32'hC000_0001, 1'b0, 32'h0, ST_OK}
	};

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [3:0]  opcode;
	logic [31:0] word_in;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [31:0] word_out;
	logic [1:0]  status;

	result_t     pending_words [$];   // expected responses, oldest first
	int          mismatches = 0;
	int          cycles = 0;
	int          tx_quiet = 0;        // words left in a no-gap run, request side
	int          rx_quiet = 0;        // draws left in a no-stall run, response side

	signed_number_format_converter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.opcode    (opcode),
		.word_in   (word_in),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.word_out  (word_out),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// six 5-bit digit groups, group k has weight 10^k
	function automatic logic [31:0] decimal_digits(logic [31:0] mag);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 6; k++) begin
			r |= (mag % 10) << (5 * k);
			mag = mag / 10;
		end
		return r;
	endfunction

	// sign plus magnitude (up to 2^31) into a decimal word
	function automatic logic [31:0] encode_decimal(logic neg, logic [32:0] mag,
			inout status_t st);
		if (mag > {1'b0, DEC_MAX}) begin
			st = ST_UNDEF;
			return '0;
		end
		if (mag == '0)
			return '0;
		return (neg ? DEC_NEG : 32'h0) | decimal_digits(mag[31:0]);
	endfunction

	// expected response for one request word
	function automatic result_t convert_word(logic [3:0] op, logic [31:0] x);
		fmt_t        src;
		fmt_t        dst;
		logic        neg;
		logic [1:0]  sg;
		logic [31:0] mag;
		logic [31:0] weight;
		logic [31:0] y;
		status_t     st;
		result_t     r;
		src = fmt_t'(op[3:2]);
		dst = fmt_t'(op[1:0]);
		neg = x[31];
		st  = ST_OK;
		y   = '0;
		case (src)
			FMT_ONES: begin
				if (x == ALL_ONES)
					y = '0;
				else if (dst == FMT_ONES || !neg) begin
					if (dst == FMT_DEC)
						y = encode_decimal(1'b0, {1'b0, x}, st);
					else
						y = x;
				end else if (dst == FMT_TWOS)
					y = x + 32'd1;
				else if (dst == FMT_SM)
					y = ~x | SIGN_BIT;
				else
					y = encode_decimal(1'b1, {1'b0, ~x & MAG_MASK}, st);
			end
			FMT_TWOS: begin
				if (dst == FMT_TWOS)
					y = x;
				else if (!neg) begin
					if (dst == FMT_DEC)
						y = encode_decimal(1'b0, {1'b0, x}, st);
					else
						y = x;
				end else if (dst == FMT_ONES) begin
					if (x == SIGN_BIT)
						st = ST_UNDEF;
					else
						y = x - 32'd1;
				end else if (dst == FMT_SM)
					y = ~(x - 32'd1) | SIGN_BIT;
				else
					y = encode_decimal(1'b1, {1'b0, ~x & MAG_MASK} + 33'd1, st);
			end
			FMT_SM: begin
				if (x == SIGN_BIT)
					y = '0;
				else if (dst == FMT_SM || !neg) begin
					if (dst == FMT_DEC)
						y = encode_decimal(1'b0, {1'b0, x & MAG_MASK}, st);
					else
						y = x;
				end else if (dst == FMT_ONES)
					y = ~x | SIGN_BIT;
				else if (dst == FMT_TWOS)
					y = (~x | SIGN_BIT) + 32'd1;
				else
					y = encode_decimal(1'b1, {1'b0, x & MAG_MASK}, st);
			end
			default: begin
				sg = x[31:30];
				if (dst == FMT_DEC)
					y = x;
				else if (sg == 2'b01 || sg == 2'b10)
					st = ST_ERROR;
				else begin
					// groups summed at full 5-bit value
					mag    = '0;
					weight = 32'd1;
					for (int k = 0; k < 6; k++) begin
						mag    = mag + ((x >> (5 * k)) & 32'h1F) * weight;
						weight = weight * 10;
					end
					if (mag > DEC_MAX)
						st = ST_UNDEF;
					else if (sg != 2'b11 || mag == '0)
						y = mag;
					else if (dst == FMT_ONES)
						y = ~mag;
					else if (dst == FMT_TWOS)
						y = ~mag + 32'd1;
					else
						y = mag | SIGN_BIT;
				end
			end
		endcase
		if (st != ST_OK)
			y = '0;
		r.word = y;
		r.st   = st;
		return r;
	endfunction

	// idle length: half none, most short, a few long, with no-gap runs
	function automatic int pick_gap(inout int quiet);
		int unsigned r;
		if (quiet > 0) begin
			quiet--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 4) begin
			quiet = $urandom_range(20, 60);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(11, 40);
	endfunction

	// random request word: mostly a value written properly in src format
	function automatic logic [31:0] random_word(fmt_t src);
		int unsigned pick;
		logic [31:0] m;
		logic        s;
		pick = $urandom_range(0, 99);
		s    = 1'($urandom_range(0, 1));
		if (pick < 20)
			return $urandom();
		if (pick < 30) begin
			case ($urandom_range(0, 7))
				0: return 32'h0;
				1: return SIGN_BIT;
				2: return ALL_ONES;
				3: return MAG_MASK;
				4: return DEC_MAX;
				5: return DEC_MAX + 32'd1;
				6: return DEC_NEG;
				default: return SIGN_BIT | 32'd1;
			endcase
		end
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: m = $urandom_range(0, 999_999);
			5, 6:          m = $urandom_range(998_000, 1_002_000);
			7:             m = $urandom_range(0, 20);
			default:       m = $urandom() & MAG_MASK;
		endcase
		case (src)
			FMT_ONES: return s ? ~m : m;
			FMT_TWOS: return s ? -m : m;
			FMT_SM:   return s ? (m | SIGN_BIT) : m;
			default:  return (s ? DEC_NEG : 32'h0) | decimal_digits(m);
		endcase
	endfunction

	// offer one word, hold it until taken, then log its expectation
	task automatic send_word(logic [3:0] op, logic [31:0] w, result_t want);
		int gap;
		gap = pick_gap(tx_quiet);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode    <= op;
		word_in   <= w;
		do
			@(posedge clk);
		while (req_stall);
		pending_words.push_back(want);
	endtask

	// response side back-pressure
	initial begin
		int n;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			n = pick_gap(rx_quiet);
			if (n > 0) begin
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// response checker: oldest expectation first
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word: word_out %h status %0d",
					$time, word_out, status);
				mismatches++;
			end else begin
				want = pending_words.pop_front();
				if (word_out !== want.word) begin
					$display("%0t: word_out expected %h actual %h",
						$time, want.word, word_out);
					mismatches++;
				end
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.st, status);
					mismatches++;
				end
			end
		end
	end

	// hard stop
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		fmt_t        src;
		fmt_t        dst;
		logic [3:0]  op;
		logic [31:0] w;
		result_t     want;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		opcode    = '0;
		word_in   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (PROBES[i]) begin
			op = {PROBES[i].src, PROBES[i].dst};
			if (PROBES[i].typed) begin
				want.word = PROBES[i].exp_word;
				want.st   = PROBES[i].exp_st;
			end else
				want = convert_word(op, PROBES[i].word);
			send_word(op, PROBES[i].word, want);
		end

		// random words
		repeat (RANDOM_WORDS) begin
			src = fmt_t'($urandom_range(0, 3));
			dst = fmt_t'($urandom_range(0, 3));
			op  = {src, dst};
			w   = random_word(src);
			send_word(op, w, convert_word(op, w));
		end
		req_valid <= 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
